// File: hw/rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants and match-tree sizing functions for the LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int FIRST_LEARNED = 256;
    localparam int TREE_FAN_BITS = 4;

    // node count at tree level l (level 0 = leaves)
    function automatic int level_count(int n, int l);
        int c;
        c = n;
        for (int k = 0; k < l; k++) begin
            c = (c + (1 << TREE_FAN_BITS) - 1) >> TREE_FAN_BITS;
        end
        return c;
    endfunction

    function automatic int tree_levels(int n);
        int c;
        int lv;
        c  = n;
        lv = 0;
        for (int k = 0; k < 32; k++) begin
            if (c > 1) begin
                c  = (c + (1 << TREE_FAN_BITS) - 1) >> TREE_FAN_BITS;
                lv = lv + 1;
            end
        end
        return lv;
    endfunction

    // offset of level l in the flat node array (levels 1 and up)
    function automatic int tree_offset(int n, int l);
        int s;
        s = 0;
        for (int m = 1; m < l; m++) begin
            s = s + level_count(n, m);
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/lzwc_cell.sv
// ----------------------------------------------------------------------------
// lzwc_cell
// One dictionary cell: holds a (prefix, byte) entry, takes its neighbor's
// entry on insert, and compares against the search key.
// ----------------------------------------------------------------------------
module lzwc_cell #(
    parameter int KW  = 20,
    parameter int PW  = 12,
    parameter int UW  = 12,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic [KW-1:0] i_entry,
    input  logic [KW-1:0] i_key,
    input  logic [UW-1:0] i_used,
    output logic [KW-1:0] o_entry,
    output logic          o_hit,
    output logic [PW-1:0] o_pos
);

    logic [KW-1:0] r_entry;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
        r_hit <= (i_used > UW'(IDX)) && (r_entry == i_key);
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_pos   = r_hit ? PW'(IDX) : '0;

endmodule

// File: hw/rtl/lzwc_match_tree.sv
// ----------------------------------------------------------------------------
// lzwc_match_tree
// Registered OR tree that folds the cell hits into one found flag and the
// position of the matching cell. At most one cell matches.
// ----------------------------------------------------------------------------
module lzwc_match_tree #(
    parameter int N_LEAF = 3840,
    parameter int PW     = 12
) (
    input  logic          i_clk,
    input  logic          i_hit [N_LEAF],
    input  logic [PW-1:0] i_pos [N_LEAF],
    output logic          o_found,
    output logic [PW-1:0] o_pos
);

    localparam int FAN    = 1 << lzwc_pkg::TREE_FAN_BITS;
    localparam int LEVELS = lzwc_pkg::tree_levels(N_LEAF);
    localparam int N_NODE = lzwc_pkg::tree_offset(N_LEAF, LEVELS + 1);

    logic          r_found [N_NODE];
    logic [PW-1:0] r_pos   [N_NODE];

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int CNT  = lzwc_pkg::level_count(N_LEAF, l);
        localparam int PREV = lzwc_pkg::level_count(N_LEAF, l - 1);
        localparam int OFF  = lzwc_pkg::tree_offset(N_LEAF, l);
        localparam int POFF = lzwc_pkg::tree_offset(N_LEAF, l - 1);
        for (genvar j = 0; j < CNT; j++) begin : g_node
            logic          n_found;
            logic [PW-1:0] n_pos;
            if (l == 1) begin : g_leaf
                always_comb begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    for (int k = 0; k < FAN; k++) begin
                        if (j * FAN + k < PREV) begin
                            n_found = n_found | i_hit[j * FAN + k];
                            n_pos   = n_pos | i_pos[j * FAN + k];
                        end
                    end
                end
            end else begin : g_inner
                always_comb begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    for (int k = 0; k < FAN; k++) begin
                        if (j * FAN + k < PREV) begin
                            n_found = n_found | r_found[POFF + j * FAN + k];
                            n_pos   = n_pos | r_pos[POFF + j * FAN + k];
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                r_found[OFF + j] <= n_found;
                r_pos[OFF + j]   <= n_pos;
            end
        end
    end

    assign o_found = r_found[N_NODE - 1];
    assign o_pos   = r_pos[N_NODE - 1];

endmodule

// File: hw/rtl/lzw_byte_compressor_core.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_core
// LZW compressor, one byte in per transfer, CODE_BITS-wide codes out.
// ----------------------------------------------------------------------------
// The dictionary is a chain of 2^CODE_BITS-256 cells; a learned entry enters
// at the head and every older entry moves one cell down, so a cell's place
// gives its code. A byte that extends the current string is looked up by the
// registered cell compare and the registered 16-way match tree (LEVELS = 3
// at 12 bits); a byte that breaks the string then emits the current code, the
// first byte of a stream just starts the string, and the last byte also emits
// the final code (tlast set). Once the dictionary is full it freezes; after
// tlast the next free code and the current string return to reset.
module lzw_byte_compressor_core #(
    parameter int CODE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,  // [7:0] data_byte
    input  logic                               i_s_axis_tlast,  // end_of_stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,  // out_code, zero pad
    output logic                               o_m_axis_tlast   // final_code
);

    localparam int CODE_LIMIT = 1 << CODE_BITS;
    localparam int DEPTH      = CODE_LIMIT - lzwc_pkg::FIRST_LEARNED;
    localparam int KW         = CODE_BITS + lzwc_pkg::BYTE_BITS;
    localparam int PW         = $clog2(DEPTH);
    localparam int UW         = $clog2(DEPTH + 1);
    localparam int NW         = CODE_BITS + 1;
    localparam int OW         = ((CODE_BITS + 7) / 8) * 8;
    localparam int LEVELS     = lzwc_pkg::tree_levels(DEPTH);
    localparam int LAT        = LEVELS + 1;
    localparam int CW         = $clog2(LAT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT_MISS,
        S_EMIT_LAST
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_cnt;
    logic [NW-1:0]           r_nfc;
    logic [CODE_BITS-1:0]    r_cur;
    logic                    r_pv;
    logic [7:0]              r_byte;
    logic                    r_eos;
    logic                    r_out_valid;
    logic [CODE_BITS-1:0]    r_out_code;
    logic                    r_out_last;

    logic                    w_accept;
    logic                    w_slot_free;
    logic                    w_load;
    logic                    w_shift;
    logic                    w_done;
    logic [KW-1:0]           w_key;
    logic [UW-1:0]           w_used;
    logic                    w_found;
    logic [PW-1:0]           w_tree_pos;
    logic [CODE_BITS-1:0]    w_hit_code;

    logic [KW-1:0]           w_entry [DEPTH];
    logic                    w_hit   [DEPTH];
    logic [PW-1:0]           w_pos   [DEPTH];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign w_load          = ((r_state == S_EMIT_MISS) || (r_state == S_EMIT_LAST)) && w_slot_free;
    assign w_shift         = (r_state == S_EMIT_MISS) && w_slot_free &&
                             (r_nfc < NW'(CODE_LIMIT));
    assign w_done          = (r_cnt == CW'(LAT));
    assign w_key           = {r_cur, r_byte};
    assign w_used          = UW'(r_nfc - NW'(lzwc_pkg::FIRST_LEARNED));
    assign w_hit_code      = CODE_BITS'(r_nfc - NW'(1) - NW'(w_tree_pos));

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        lzwc_cell #(
            .KW  (KW),
            .PW  (PW),
            .UW  (UW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_entry ((i == 0) ? w_key : w_entry[(i == 0) ? 0 : i - 1]),
            .i_key   (w_key),
            .i_used  (w_used),
            .o_entry (w_entry[i]),
            .o_hit   (w_hit[i]),
            .o_pos   (w_pos[i])
        );
    end

    lzwc_match_tree #(
        .N_LEAF (DEPTH),
        .PW     (PW)
    ) u_tree (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .i_pos   (w_pos),
        .o_found (w_found),
        .o_pos   (w_tree_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_nfc       <= NW'(lzwc_pkg::FIRST_LEARNED);
            r_cur       <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_byte <= i_s_axis_tdata;
                        r_eos  <= i_s_axis_tlast;
                        r_cnt  <= '0;
                        if (!r_pv) begin
                            r_cur   <= CODE_BITS'(i_s_axis_tdata);
                            r_pv    <= 1'b1;
                            r_state <= i_s_axis_tlast ? S_EMIT_LAST : S_IDLE;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (w_done) begin
                        if (w_found) begin
                            r_cur   <= w_hit_code;
                            r_state <= r_eos ? S_EMIT_LAST : S_IDLE;
                        end else begin
                            r_state <= S_EMIT_MISS;
                        end
                    end
                end
                S_EMIT_MISS: begin
                    if (w_slot_free) begin
                        r_out_code <= r_cur;
                        r_out_last <= 1'b0;
                        if (w_shift) begin
                            r_nfc <= r_nfc + NW'(1);
                        end
                        r_cur   <= CODE_BITS'(r_byte);
                        r_state <= r_eos ? S_EMIT_LAST : S_IDLE;
                    end
                end
                S_EMIT_LAST: begin
                    if (w_slot_free) begin
                        r_out_code <= r_cur;
                        r_out_last <= 1'b1;
                        r_nfc      <= NW'(lzwc_pkg::FIRST_LEARNED);
                        r_cur      <= '0;
                        r_pv       <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OW'(r_out_code);
    assign o_m_axis_tlast  = r_out_last;

    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfc >= NW'(lzwc_pkg::FIRST_LEARNED)) && (r_nfc <= NW'(CODE_LIMIT)))
        else $error("next free code out of range");

    a_learn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |=> (r_nfc == $past(r_nfc) + NW'(1)))
        else $error("insert did not advance next free code");

    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && w_done && w_found) |->
        ((w_hit_code >= CODE_BITS'(lzwc_pkg::FIRST_LEARNED)) &&
         (NW'(w_hit_code) < r_nfc)))
        else $error("matched code outside learned range");

    a_stream_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT_LAST) && w_slot_free) |=>
        ((r_nfc == NW'(lzwc_pkg::FIRST_LEARNED)) && !r_pv && r_out_valid && r_out_last))
        else $error("end of stream did not restart dictionary");

    a_search_has_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> r_pv)
        else $error("search without current string");

endmodule
